/* rtl/assert_macros.svh */
// Assertion macros shared by the waveform generator RTL.
// Every check runs on clk_i and is masked while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define MMWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: when pre holds, post must hold on the next edge.
`define MMWG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/mmwg_pkg.sv */
// Shared types, constants and the cosine table of the waveform generator.
// No dependencies; the other RTL files, apart from assert_macros.svh, import this package.
`default_nettype none

package mmwg_pkg;

  localparam int unsigned LevelW     = 10;
  localparam int unsigned StepW      = 10;
  localparam int unsigned BounceW    = 8;
  localparam int unsigned BtnW       = 4;
  localparam int unsigned AdcW       = 12;
  localparam int unsigned DacW       = 16;
  localparam int unsigned CmdW       = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned TablePosW  = $clog2(TableDepth);

  localparam logic [LevelW-1:0]  LevelMax      = 10'd1023;
  localparam logic [StepW-1:0]   StepReset     = 10'd16;
  localparam logic [BounceW-1:0] BounceReset   = 8'd30;
  localparam logic [BounceW-1:0] SinceMax      = 8'd255;
  localparam logic [CmdW-1:0]    CmdChanA      = 8'b0001_0000;
  localparam logic [CmdW-1:0]    CmdChanB      = 8'b1001_0000;
  localparam logic [BtnW-1:0]    BtnNonePushed = 4'hF;

  typedef enum logic [ModeW-1:0] {
    MODE_SAW = 2'd0,
    MODE_TRI = 2'd1,
    MODE_COS = 2'd2,
    MODE_ADC = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_SIZE    = 2'd0,
    REG_BOUNCE_TICKS = 2'd1,
    REG_CHANNEL_B    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [StepW-1:0]   step_size;
    logic [BounceW-1:0] bounce_ticks;
    logic               channel_b;
  } cfg_t;

  // Slightly more than one period of an offset cosine, full scale 0..1023.
  localparam logic [LevelW-1:0] CosRom [TableDepth] = '{
    10'd1023, 10'd1021, 10'd1013, 10'd1001, 10'd984,  10'd962,  10'd936,  10'd906,
    10'd872,  10'd834,  10'd793,  10'd749,  10'd702,  10'd654,  10'd604,  10'd553,
    10'd512,  10'd461,  10'd410,  10'd360,  10'd312,  10'd265,  10'd221,  10'd180,
    10'd142,  10'd108,  10'd78,   10'd52,   10'd30,   10'd13,   10'd1,    10'd0,
    10'd1,    10'd13,   10'd30,   10'd52,   10'd78,   10'd108,  10'd142,  10'd180,
    10'd221,  10'd265,  10'd312,  10'd360,  10'd410,  10'd461,  10'd512,  10'd553,
    10'd604,  10'd654,  10'd702,  10'd749,  10'd793,  10'd834,  10'd872,  10'd906,
    10'd936,  10'd962,  10'd984,  10'd1001, 10'd1013, 10'd1021, 10'd1023, 10'd1021
  };

endpackage

`default_nettype wire

/* rtl/mmwg_in_if.sv */
// Tick channel into the waveform generator: buttons and converter sample.
// Depends on mmwg_pkg for field widths.
`default_nettype none

interface mmwg_in_if;
  import mmwg_pkg::*;

  logic                valid;
  logic                ready;
  logic [BtnW-1:0]     buttons_n;
  logic [AdcW-1:0]     adc_sample;

  modport source (output valid, output buttons_n, output adc_sample, input ready);
  modport sink   (input valid, input buttons_n, input adc_sample, output ready);
endinterface

`default_nettype wire

/* rtl/mmwg_out_if.sv */
// Result channel out of the waveform generator: DAC command word and mode.
// Depends on mmwg_pkg for field widths.
`default_nettype none

interface mmwg_out_if;
  import mmwg_pkg::*;

  logic              valid;
  logic              ready;
  logic [DacW-1:0]   dac_word;
  logic [ModeW-1:0]  active_mode;

  modport source (output valid, output dac_word, output active_mode, input ready);
  modport sink   (input valid, input dac_word, input active_mode, output ready);
endinterface

`default_nettype wire

/* rtl/multi_mode_waveform_generator.sv */
// Top level of the multi-mode waveform generator.
// Depends on mmwg_pkg, mmwg_in_if, mmwg_out_if, mmwg_cfg, mmwg_sel, mmwg_wave.
`default_nettype none
`include "assert_macros.svh"

// One input beat is one tick: button levels pick sawtooth, cosine, triangle or
// converter follower (sw1..sw4, lowest-numbered pressed button wins, ignored
// during the lockout), and every tick yields exactly one 16-bit DAC command word
// plus the mode used. A beat is taken every cycle while in_i.ready is high; it is
// held in the input register, then its result in the result register. The
// waveform update is a single add/compare and table read between those two
// registers. in_i.ready follows out_o.ready combinationally, so the block stalls
// only while both registers are full and the held result is not taken. The user
// must write configuration through cfg_we_i/cfg_idx_i/cfg_data_i only while no
// beat is in flight; the block itself does not enforce this.
module multi_mode_waveform_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mmwg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mmwg_pkg::CfgDataW-1:0] cfg_data_i,
  mmwg_in_if.sink                            in_i,
  mmwg_out_if.source                         out_o
);
  import mmwg_pkg::*;

  cfg_t               cfg;
  logic               in_valid_q;
  logic [BtnW-1:0]    btn_q;
  logic [AdcW-1:0]    adc_q;
  logic               out_valid_q;
  logic [DacW-1:0]    dac_q, dac_d;
  mode_e              mode_q;
  mode_e              mode;
  logic [LevelW-1:0]  level;
  logic [CmdW-1:0]    cmd;
  logic               advance;
  logic               fire;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  mmwg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mmwg_sel u_sel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (fire),
    .buttons_n_i    (btn_q),
    .bounce_ticks_i (cfg.bounce_ticks),
    .mode_o         (mode)
  );

  mmwg_wave u_wave (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (fire),
    .mode_i       (mode),
    .step_size_i  (cfg.step_size),
    .adc_sample_i (adc_q),
    .level_o      (level)
  );

  assign cmd   = cfg.channel_b ? CmdChanB : CmdChanA;
  assign dac_d = {cmd, {(DacW-CmdW){1'b0}}} | {{(DacW-LevelW-2){1'b0}}, level, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: load on the beat, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      btn_q <= in_i.buttons_n;
      adc_q <= in_i.adc_sample;
    end
    if (fire) begin
      dac_q  <= dac_d;
      mode_q <= mode;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.dac_word    = dac_q;
  assign out_o.active_mode = mode_q;

  `MMWG_ASSERT_NEXT(a_fire_result, fire, out_valid_q,
                    "accepted tick produced no result")
  `MMWG_ASSERT_NEXT(a_stall_keeps_tick, in_valid_q && !advance, in_valid_q && $stable(btn_q),
                    "pending tick lost while output stalled")
  `MMWG_ASSERT_NEXT(a_out_holds, out_valid_q && !out_o.ready,
                    out_valid_q && $stable(dac_q) && $stable(mode_q),
                    "held result changed before it was taken")

endmodule

`default_nettype wire

/* rtl/mmwg_cfg.sv */
// Configuration register bank: step size, button lockout, DAC channel.
// Depends on mmwg_pkg.
`default_nettype none

module mmwg_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mmwg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mmwg_pkg::CfgDataW-1:0] cfg_data_i,
  output mmwg_pkg::cfg_t                     cfg_o
);
  import mmwg_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size    <= StepReset;
      cfg_q.bounce_ticks <= BounceReset;
      cfg_q.channel_b    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_SIZE:    cfg_q.step_size    <= cfg_data_i[StepW-1:0];
        REG_BOUNCE_TICKS: cfg_q.bounce_ticks <= cfg_data_i[BounceW-1:0];
        REG_CHANNEL_B:    cfg_q.channel_b    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/mmwg_sel.sv */
// Button scan with press lockout; holds the active waveform mode.
// Depends on mmwg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mmwg_sel (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_en_i,
  input  wire logic [mmwg_pkg::BtnW-1:0]     buttons_n_i,
  input  wire logic [mmwg_pkg::BounceW-1:0]  bounce_ticks_i,
  output mmwg_pkg::mode_e                    mode_o
);
  import mmwg_pkg::*;

  mode_e              mode_q, mode_d;
  logic [BounceW-1:0] since_q, since_d;
  logic               hit;
  mode_e              pick;

  // Priority sw1, sw2, sw3, sw4 (active low).
  always_comb begin
    pick = MODE_ADC;
    if (!buttons_n_i[0]) begin
      pick = MODE_SAW;
    end else if (!buttons_n_i[1]) begin
      pick = MODE_COS;
    end else if (!buttons_n_i[2]) begin
      pick = MODE_TRI;
    end
  end

  assign hit    = (since_q >= bounce_ticks_i) && (buttons_n_i != BtnNonePushed);
  assign mode_d = hit ? pick : mode_q;
  assign mode_o = mode_d;

  // Clear on a press, then count this tick; saturate at the top.
  always_comb begin
    if (hit) begin
      since_d = BounceW'(1);
    end else if (since_q != SinceMax) begin
      since_d = since_q + BounceW'(1);
    end else begin
      since_d = since_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SAW;
      since_q <= '0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      since_q <= since_d;
    end
  end

  `MMWG_ASSERT_NEXT(a_press_restarts, step_en_i && hit, since_q == BounceW'(1),
                    "lockout counter not restarted after press")
  `MMWG_ASSERT_NEXT(a_mode_holds, !step_en_i || !hit, $stable(mode_q),
                    "mode changed without an accepted press")
  `MMWG_ASSERT_NEXT(a_since_holds, !step_en_i, $stable(since_q),
                    "lockout counter moved without a tick")

endmodule

`default_nettype wire

/* rtl/mmwg_wave.sv */
// Waveform state for sawtooth, triangle and cosine; level mux for all modes.
// Depends on mmwg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mmwg_wave (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_en_i,
  input  wire mmwg_pkg::mode_e               mode_i,
  input  wire logic [mmwg_pkg::StepW-1:0]    step_size_i,
  input  wire logic [mmwg_pkg::AdcW-1:0]     adc_sample_i,
  output logic      [mmwg_pkg::LevelW-1:0]   level_o
);
  import mmwg_pkg::*;

  logic [LevelW-1:0]     saw_q, saw_d;
  logic [LevelW-1:0]     tri_q, tri_d;
  logic                  rising_q, rising_d;
  logic [TablePosW-1:0]  pos_q, pos_d;
  logic [LevelW:0]       saw_sum, tri_sum;

  assign saw_sum = {1'b0, saw_q} + {1'b0, step_size_i};
  assign saw_d   = (saw_sum > {1'b0, LevelMax}) ? '0 : saw_sum[LevelW-1:0];

  assign tri_sum = {1'b0, tri_q} + {1'b0, step_size_i};

  // Clamp at either end and turn around.
  always_comb begin
    tri_d    = tri_q;
    rising_d = rising_q;
    if (rising_q) begin
      if (tri_sum >= {1'b0, LevelMax}) begin
        tri_d    = LevelMax;
        rising_d = 1'b0;
      end else begin
        tri_d = tri_sum[LevelW-1:0];
      end
    end else begin
      if (tri_q <= step_size_i) begin
        tri_d    = '0;
        rising_d = 1'b1;
      end else begin
        tri_d = tri_q - step_size_i;
      end
    end
  end

  assign pos_d = pos_q + TablePosW'(1);

  always_comb begin
    case (mode_i)
      MODE_SAW: level_o = saw_d;
      MODE_TRI: level_o = tri_d;
      MODE_COS: level_o = CosRom[pos_q];
      default:  level_o = adc_sample_i[AdcW-1 -: LevelW];
    endcase
  end

  // Advance only the waveform that is active this tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_q    <= '0;
      tri_q    <= '0;
      rising_q <= 1'b1;
      pos_q    <= '0;
    end else if (step_en_i) begin
      case (mode_i)
        MODE_SAW: saw_q <= saw_d;
        MODE_TRI: begin
          tri_q    <= tri_d;
          rising_q <= rising_d;
        end
        MODE_COS: pos_q <= pos_d;
        default: ;
      endcase
    end
  end

  `MMWG_ASSERT(a_tri_top, $fell(rising_q) |-> (tri_q == LevelMax),
               "triangle turned down below full scale")
  `MMWG_ASSERT(a_tri_bottom, $rose(rising_q) |-> (tri_q == '0),
               "triangle turned up above zero")
  `MMWG_ASSERT_NEXT(a_pos_idle, !step_en_i || (mode_i != MODE_COS), $stable(pos_q),
                    "table position moved outside cosine mode")

endmodule

`default_nettype wire
